[rtl/erp_pkg.sv]
// Shared types and constants for the Euler rotation pipeline.
`default_nettype none

package erp_pkg;

   // CORDIC settings: number of micro-rotations and the internal angle width.
   localparam int CORDIC_STEPS = 30;
   localparam int ANGLE_BITS   = 32;

   // Sine and cosine are carried in Q2.30 with headroom for intermediate growth.
   localparam int TRIG_WIDTH = 34;
   localparam int SC_WIDTH   = 2 * TRIG_WIDTH;

   // Products of a coordinate and a Q2.30 trig value are scaled back by this shift.
   localparam int ROUND_SHIFT = 30;

   // Start value of the CORDIC x register: the inverse gain 0.60725 in Q2.30.
   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = TRIG_WIDTH'(652032874);

   // Arctangent of 2^-i as a binary angle, 2^32 being one full turn.
   localparam logic [ANGLE_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1
   };

   typedef logic signed [TRIG_WIDTH-1:0] trig_type;

   typedef struct packed {
      trig_type cosine;
      trig_type sine;
   } sincos_type;

endpackage

`default_nettype wire

[rtl/erp_cordic.sv]
// Pipelined rotation-mode CORDIC producing sine and cosine for three angles.
`default_nettype none

module erp_cordic #(
   parameter int ANGLE_WIDTH = 32,
   parameter int SIDE_WIDTH  = 96
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  logic [ANGLE_WIDTH-1:0] in_phi,
   input  logic [ANGLE_WIDTH-1:0] in_theta,
   input  logic [ANGLE_WIDTH-1:0] in_psi,
   input  logic [SIDE_WIDTH-1:0]  in_side,
   output logic                   out_valid,
   output erp_pkg::sincos_type    out_phi,
   output erp_pkg::sincos_type    out_theta,
   output erp_pkg::sincos_type    out_psi,
   output logic [SIDE_WIDTH-1:0]  out_side
);
   import erp_pkg::*;

   localparam int NUM_LANES  = 3;
   localparam int LANE_PSI   = 0;
   localparam int LANE_THETA = 1;
   localparam int LANE_PHI   = 2;
   localparam int NUM_STAGES = CORDIC_STEPS + 2;
   localparam int LAST       = NUM_STAGES - 1;
   localparam int PAD        = ANGLE_BITS - ANGLE_WIDTH;
   localparam int ZEXT       = TRIG_WIDTH - ANGLE_BITS;

   typedef struct packed {
      logic signed [TRIG_WIDTH-1:0] x;
      logic signed [TRIG_WIDTH-1:0] y;
      logic signed [TRIG_WIDTH-1:0] z;
      logic                         flip;
   } lane_type;

   lane_type               lane_ff  [NUM_STAGES][NUM_LANES];
   lane_type               lane_in  [NUM_STAGES][NUM_LANES];
   logic [SIDE_WIDTH-1:0]  side_ff  [NUM_STAGES];
   logic [SIDE_WIDTH-1:0]  side_in  [NUM_STAGES];
   logic                   valid_ff [NUM_STAGES];
   logic                   valid_in [NUM_STAGES];
   logic [ANGLE_WIDTH-1:0] angle    [NUM_LANES];

   assign angle[LANE_PSI]   = in_psi;
   assign angle[LANE_THETA] = in_theta;
   assign angle[LANE_PHI]   = in_phi;

   genvar s, l;

   // Entry stage: scale the angle to a full 32-bit turn and fold it into the
   // right half plane; a folded angle has its results negated at the end.
   generate
      for (l = 0; l < NUM_LANES; l++) begin : g_pre
         logic [ANGLE_BITS-1:0] full;
         logic                  flip;
         logic                  top;
         assign full = ANGLE_BITS'(angle[l]) << PAD;
         assign flip = full[ANGLE_BITS-1] ^ full[ANGLE_BITS-2];
         assign top  = full[ANGLE_BITS-1] ^ flip;
         assign lane_in[0][l] = '{
            x:    CORDIC_GAIN,
            y:    '0,
            z:    {{ZEXT{top}}, top, full[ANGLE_BITS-2:0]},
            flip: flip
         };
      end

      // One micro-rotation per stage.
      for (s = 1; s <= CORDIC_STEPS; s++) begin : g_iter
         for (l = 0; l < NUM_LANES; l++) begin : g_lane
            localparam int I = s - 1;
            lane_type                     cur;
            logic signed [TRIG_WIDTH-1:0] dx;
            logic signed [TRIG_WIDTH-1:0] dy;
            logic signed [TRIG_WIDTH-1:0] step;
            assign cur  = lane_ff[s-1][l];
            assign dx   = $signed(cur.y) >>> I;
            assign dy   = $signed(cur.x) >>> I;
            assign step = $signed({{ZEXT{1'b0}}, ATAN_TAB[I]});
            always_comb begin
               if (!cur.z[TRIG_WIDTH-1]) begin
                  lane_in[s][l] = '{x: cur.x - dx, y: cur.y + dy, z: cur.z - step,
                                    flip: cur.flip};
               end else begin
                  lane_in[s][l] = '{x: cur.x + dx, y: cur.y - dy, z: cur.z + step,
                                    flip: cur.flip};
               end
            end
         end
      end

      // Exit stage: undo the half-plane fold.
      for (l = 0; l < NUM_LANES; l++) begin : g_neg
         lane_type cur;
         assign cur = lane_ff[LAST-1][l];
         always_comb begin
            if (cur.flip) begin
               lane_in[LAST][l] = '{x: -cur.x, y: -cur.y, z: cur.z, flip: cur.flip};
            end else begin
               lane_in[LAST][l] = cur;
            end
         end
      end

      for (s = 0; s < NUM_STAGES; s++) begin : g_reg
         if (s == 0) begin : g_first
            assign valid_in[s] = in_valid;
            assign side_in[s]  = in_side;
         end else begin : g_next
            assign valid_in[s] = valid_ff[s-1];
            assign side_in[s]  = side_ff[s-1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (enable) begin
               valid_ff[s] <= valid_in[s];
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               side_ff[s] <= side_in[s];
               for (int k = 0; k < NUM_LANES; k++) begin
                  lane_ff[s][k] <= lane_in[s][k];
               end
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[LAST];
   assign out_side  = side_ff[LAST];
   assign out_psi   = '{cosine: lane_ff[LAST][LANE_PSI].x,   sine: lane_ff[LAST][LANE_PSI].y};
   assign out_theta = '{cosine: lane_ff[LAST][LANE_THETA].x, sine: lane_ff[LAST][LANE_THETA].y};
   assign out_phi   = '{cosine: lane_ff[LAST][LANE_PHI].x,   sine: lane_ff[LAST][LANE_PHI].y};

endmodule

`default_nettype wire

[rtl/erp_rotate.sv]
// Four-stage planar rotation: r0 = a0*cos - a1*sin, r1 = a0*sin + a1*cos.
`default_nettype none

module erp_rotate #(
   parameter int DATA_WIDTH = 35,
   parameter int SIDE_WIDTH = 35
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic signed [DATA_WIDTH-1:0] in_a0,
   input  logic signed [DATA_WIDTH-1:0] in_a1,
   input  erp_pkg::sincos_type          in_trig,
   input  logic [SIDE_WIDTH-1:0]        in_side,
   output logic                         out_valid,
   output logic signed [DATA_WIDTH-1:0] out_r0,
   output logic signed [DATA_WIDTH-1:0] out_r1,
   output logic [SIDE_WIDTH-1:0]        out_side
);
   import erp_pkg::*;

   localparam int NUM_STAGES   = 4;
   localparam int NUM_PRODUCTS = 4;
   localparam int MAG_WIDTH    = TRIG_WIDTH - 1;
   localparam int LO_WIDTH     = DATA_WIDTH / 2;
   localparam int HI_WIDTH     = DATA_WIDTH - LO_WIDTH;
   localparam int HI_PWIDTH    = HI_WIDTH + MAG_WIDTH;
   localparam int LO_PWIDTH    = LO_WIDTH + MAG_WIDTH;
   localparam int SUM_WIDTH    = DATA_WIDTH + MAG_WIDTH + 1;
   localparam logic [SUM_WIDTH-1:0] ROUND_BIAS = SUM_WIDTH'(1) << (ROUND_SHIFT - 1);

   logic                         valid_ff [NUM_STAGES];
   logic [SIDE_WIDTH-1:0]        side_ff  [NUM_STAGES];

   logic [DATA_WIDTH-1:0]        mag_a_ff [2];
   logic [DATA_WIDTH-1:0]        mag_a_in [2];
   logic [MAG_WIDTH-1:0]         mag_t_ff [2];
   logic [MAG_WIDTH-1:0]         mag_t_in [2];
   logic                         neg_ff   [NUM_PRODUCTS];
   logic                         neg_in   [NUM_PRODUCTS];
   logic                         neg2_ff  [NUM_PRODUCTS];
   logic [HI_PWIDTH-1:0]         hi_ff    [NUM_PRODUCTS];
   logic [HI_PWIDTH-1:0]         hi_in    [NUM_PRODUCTS];
   logic [LO_PWIDTH-1:0]         lo_ff    [NUM_PRODUCTS];
   logic [LO_PWIDTH-1:0]         lo_in    [NUM_PRODUCTS];
   logic signed [DATA_WIDTH-1:0] prod_ff  [NUM_PRODUCTS];
   logic signed [DATA_WIDTH-1:0] prod_in  [NUM_PRODUCTS];
   logic signed [DATA_WIDTH-1:0] r0_ff;
   logic signed [DATA_WIDTH-1:0] r1_ff;

   logic sign_a0, sign_a1, sign_c, sign_s;
   trig_type neg_c, neg_s;

   // Stage one: magnitudes and product signs. The products are numbered
   // a0*cos, a1*sin, a0*sin, a1*cos.
   assign sign_a0 = in_a0[DATA_WIDTH-1];
   assign sign_a1 = in_a1[DATA_WIDTH-1];
   assign sign_c  = in_trig.cosine[TRIG_WIDTH-1];
   assign sign_s  = in_trig.sine[TRIG_WIDTH-1];
   assign neg_c   = -in_trig.cosine;
   assign neg_s   = -in_trig.sine;

   assign mag_a_in[0] = sign_a0 ? DATA_WIDTH'(-in_a0) : DATA_WIDTH'(in_a0);
   assign mag_a_in[1] = sign_a1 ? DATA_WIDTH'(-in_a1) : DATA_WIDTH'(in_a1);
   assign mag_t_in[0] = sign_c ? neg_c[MAG_WIDTH-1:0] : in_trig.cosine[MAG_WIDTH-1:0];
   assign mag_t_in[1] = sign_s ? neg_s[MAG_WIDTH-1:0] : in_trig.sine[MAG_WIDTH-1:0];
   assign neg_in[0]   = sign_a0 ^ sign_c;
   assign neg_in[1]   = sign_a1 ^ sign_s;
   assign neg_in[2]   = sign_a0 ^ sign_s;
   assign neg_in[3]   = sign_a1 ^ sign_c;

   genvar k;
   generate
      for (k = 0; k < NUM_PRODUCTS; k++) begin : g_prod
         localparam int AI = k % 2;
         localparam int TI = (k == 1 || k == 2) ? 1 : 0;
         logic [SUM_WIDTH-1:0]  sum;
         logic [DATA_WIDTH-1:0] mag;

         // Stage two: split partial products of the magnitudes.
         assign hi_in[k] = HI_PWIDTH'(mag_a_ff[AI][DATA_WIDTH-1:LO_WIDTH])
                         * HI_PWIDTH'(mag_t_ff[TI]);
         assign lo_in[k] = LO_PWIDTH'(mag_a_ff[AI][LO_WIDTH-1:0])
                         * LO_PWIDTH'(mag_t_ff[TI]);

         // Stage three: merge, round half away from zero, apply the sign.
         assign sum = (SUM_WIDTH'(hi_ff[k]) << LO_WIDTH) + SUM_WIDTH'(lo_ff[k]) + ROUND_BIAS;
         assign mag = sum[ROUND_SHIFT +: DATA_WIDTH];
         assign prod_in[k] = neg2_ff[k] ? -$signed(mag) : $signed(mag);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < NUM_STAGES; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < NUM_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         for (int i = 0; i < 2; i++) begin
            mag_a_ff[i] <= mag_a_in[i];
            mag_t_ff[i] <= mag_t_in[i];
         end
         for (int i = 0; i < NUM_PRODUCTS; i++) begin
            neg_ff[i]  <= neg_in[i];
            neg2_ff[i] <= neg_ff[i];
            hi_ff[i]   <= hi_in[i];
            lo_ff[i]   <= lo_in[i];
            prod_ff[i] <= prod_in[i];
         end
         // Stage four: the two output sums.
         r0_ff <= prod_ff[0] - prod_ff[1];
         r1_ff <= prod_ff[2] + prod_ff[3];
      end
   end

   assign out_valid = valid_ff[NUM_STAGES-1];
   assign out_side  = side_ff[NUM_STAGES-1];
   assign out_r0    = r0_ff;
   assign out_r1    = r1_ff;

endmodule

`default_nettype wire

[rtl/euler_rotate_3d_point.sv]
// Top level of the ZYX Euler rotation pipeline for Q16.16 points.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  point x, y, z and angles phi, theta, psi
//   rsp_      out        rsp_valid / rsp_ready  rotated x, y, z
//
// One transaction enters per cycle while req_ready is high and one result
// leaves per cycle while rsp_ready is high. Stages: 32 CORDIC (entry fold, 30
// micro-rotations, exit unfold), three 4-stage rotations, the output register.
// Reset clears only valid bits; data is not reset and there is no clearing pass.
// A stalled result sits in the output register while the pipeline keeps moving;
// one more result lands in a skid register, and only then does req_ready drop.
`default_nettype none

module euler_rotate_3d_point #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_phi,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_theta,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle_psi,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_x,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_y,
   output logic signed [COORD_WIDTH-1:0] rsp_rotated_z
);
   import erp_pkg::*;

   // Intermediate sums are kept wide enough that they never wrap; only the
   // final coordinates are saturated.
   localparam int DATA_WIDTH = COORD_WIDTH + 3;
   localparam int EXT        = DATA_WIDTH - COORD_WIDTH;
   localparam int CSIDE      = 3 * COORD_WIDTH;
   localparam int R1_SIDE    = DATA_WIDTH + 2 * SC_WIDTH;
   localparam int R2_SIDE    = DATA_WIDTH + SC_WIDTH;
   localparam int R3_SIDE    = DATA_WIDTH;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } point_type;

   function automatic logic signed [COORD_WIDTH-1:0] saturate(
      input logic signed [DATA_WIDTH-1:0] v
   );
      logic fits;
      fits = (&v[DATA_WIDTH-1:COORD_WIDTH-1]) | ~(|v[DATA_WIDTH-1:COORD_WIDTH-1]);
      if (fits) begin
         return v[COORD_WIDTH-1:0];
      end else if (v[DATA_WIDTH-1]) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   endfunction

   // The whole pipeline advances together unless the skid register is full.
   logic run;

   logic                  cordic_valid;
   sincos_type            trig_phi, trig_theta, trig_psi;
   logic [CSIDE-1:0]      cordic_side;

   logic signed [DATA_WIDTH-1:0] ext_x, ext_y, ext_z;

   logic                         r1_valid;
   logic signed [DATA_WIDTH-1:0] x1, y1;
   logic [R1_SIDE-1:0]           r1_side;

   logic                         r2_valid;
   logic signed [DATA_WIDTH-1:0] z2, x2;
   logic [R2_SIDE-1:0]           r2_side;

   logic                         pipe_valid;
   logic signed [DATA_WIDTH-1:0] y3, z3, x2_late;
   logic [R3_SIDE-1:0]           r3_side;

   point_type pipe_point;
   point_type rsp_point_ff, rsp_point_in;
   point_type skid_point_ff, skid_point_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      skid_valid_ff, skid_valid_in;

   assign run       = ~skid_valid_ff;
   assign req_ready = run;

   // Sine and cosine of all three angles; the coordinates ride alongside.
   erp_cordic #(
      .ANGLE_WIDTH (ANGLE_WIDTH),
      .SIDE_WIDTH  (CSIDE)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .enable    (run),
      .in_valid  (req_valid),
      .in_phi    (req_angle_phi),
      .in_theta  (req_angle_theta),
      .in_psi    (req_angle_psi),
      .in_side   ({req_point_x, req_point_y, req_point_z}),
      .out_valid (cordic_valid),
      .out_phi   (trig_phi),
      .out_theta (trig_theta),
      .out_psi   (trig_psi),
      .out_side  (cordic_side)
   );

   assign ext_x = {{EXT{cordic_side[CSIDE-1]}}, cordic_side[CSIDE-1 -: COORD_WIDTH]};
   assign ext_y = {{EXT{cordic_side[2*COORD_WIDTH-1]}},
                   cordic_side[2*COORD_WIDTH-1 -: COORD_WIDTH]};
   assign ext_z = {{EXT{cordic_side[COORD_WIDTH-1]}}, cordic_side[COORD_WIDTH-1:0]};

   // Rotation about z by psi: x1 = x cos - y sin, y1 = x sin + y cos.
   erp_rotate #(
      .DATA_WIDTH (DATA_WIDTH),
      .SIDE_WIDTH (R1_SIDE)
   ) u_rot_psi (
      .clock     (clock),
      .reset     (reset),
      .enable    (run),
      .in_valid  (cordic_valid),
      .in_a0     (ext_x),
      .in_a1     (ext_y),
      .in_trig   (trig_psi),
      .in_side   ({ext_z, trig_theta, trig_phi}),
      .out_valid (r1_valid),
      .out_r0    (x1),
      .out_r1    (y1),
      .out_side  (r1_side)
   );

   // Rotation about y by theta: z2 = z cos - x1 sin, x2 = z sin + x1 cos.
   erp_rotate #(
      .DATA_WIDTH (DATA_WIDTH),
      .SIDE_WIDTH (R2_SIDE)
   ) u_rot_theta (
      .clock     (clock),
      .reset     (reset),
      .enable    (run),
      .in_valid  (r1_valid),
      .in_a0     ($signed(r1_side[R1_SIDE-1 -: DATA_WIDTH])),
      .in_a1     (x1),
      .in_trig   (sincos_type'(r1_side[2*SC_WIDTH-1 -: SC_WIDTH])),
      .in_side   ({y1, r1_side[SC_WIDTH-1:0]}),
      .out_valid (r2_valid),
      .out_r0    (z2),
      .out_r1    (x2),
      .out_side  (r2_side)
   );

   // Rotation about x by phi: y3 = y1 cos - z2 sin, z3 = y1 sin + z2 cos.
   erp_rotate #(
      .DATA_WIDTH (DATA_WIDTH),
      .SIDE_WIDTH (R3_SIDE)
   ) u_rot_phi (
      .clock     (clock),
      .reset     (reset),
      .enable    (run),
      .in_valid  (r2_valid),
      .in_a0     ($signed(r2_side[R2_SIDE-1 -: DATA_WIDTH])),
      .in_a1     (z2),
      .in_trig   (sincos_type'(r2_side[SC_WIDTH-1:0])),
      .in_side   (x2),
      .out_valid (pipe_valid),
      .out_r0    (y3),
      .out_r1    (z3),
      .out_side  (r3_side)
   );

   assign x2_late    = $signed(r3_side);
   assign pipe_point = '{x: saturate(x2_late), y: saturate(y3), z: saturate(z3)};

   // Output register plus one skid entry. While the skid is empty the
   // pipeline moves, and its last item goes to the output register if that
   // is free or being taken, otherwise to the skid.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_point_in  = rsp_point_ff;
      skid_valid_in = skid_valid_ff;
      skid_point_in = skid_point_ff;
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            rsp_point_in  = skid_point_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_in = pipe_valid;
         rsp_point_in = pipe_point;
      end else if (pipe_valid) begin
         skid_valid_in = 1'b1;
         skid_point_in = pipe_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_point_ff  <= rsp_point_in;
      skid_point_ff <= skid_point_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rotated_x = rsp_point_ff.x;
   assign rsp_rotated_y = rsp_point_ff.y;
   assign rsp_rotated_z = rsp_point_ff.z;

   // The skid only ever holds a second result behind a waiting one.
   a_skid_behind_output : assert property (
      @(posedge clock) disable iff (reset) skid_valid_ff |-> rsp_valid_ff
   ) else $error("skid entry held without a pending output");

   // The skid fills only when the output was stalled in the previous cycle.
   a_skid_fill_on_stall : assert property (
      @(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ready)
   ) else $error("skid filled while the output was free");

   // A result leaving the pipeline is always captured.
   a_no_drop : assert property (
      @(posedge clock) disable iff (reset) (pipe_valid && run) |=> rsp_valid_ff
   ) else $error("pipeline result dropped");

   // Draining the skid moves its entry into the output register.
   a_skid_drain : assert property (
      @(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> (rsp_valid_ff && !skid_valid_ff)
   ) else $error("skid entry not moved to output");

endmodule

`default_nettype wire
